### rtl/bresenham_line_rasterizer_macros.svh
// ----------------------------------------------------------------------------
// Bresenham line rasterizer assertion macros
// Shared concurrent assertion forms for the rasterizer RTL.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rasterizer assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define BRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rasterizer assertion failed (next cycle)");

`endif

### rtl/brl_pkg.sv
// ----------------------------------------------------------------------------
// Rasterizer package
// Item kind codes and the line direction flags shared by the modules.
// ----------------------------------------------------------------------------
package brl_pkg;

  typedef enum logic {
    KIND_START   = 1'b0,
    KIND_ADVANCE = 1'b1
  } brl_kind_e;

  // Direction of the line being walked.
  typedef struct packed {
    logic steep;       // major axis is y
    logic minor_down;  // minor coordinate falls along the line
  } brl_flags_t;

endpackage

### rtl/brl_setup.sv
// ----------------------------------------------------------------------------
// Rasterizer line setup
// Picks the major axis, orders the endpoints and derives the error terms.
// ----------------------------------------------------------------------------
module brl_setup #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]        start_x_i,
  input  logic [COORD_BITS-1:0]        start_y_i,
  input  logic [COORD_BITS-1:0]        end_x_i,
  input  logic [COORD_BITS-1:0]        end_y_i,
  output logic [COORD_BITS-1:0]        cur_x_o,
  output logic [COORD_BITS-1:0]        cur_y_o,
  output logic [COORD_BITS-1:0]        major_end_o,
  output logic signed [COORD_BITS+2:0] err_o,
  output logic [COORD_BITS+1:0]        inc_s_o,
  output logic signed [COORD_BITS+2:0] inc_d_o,
  output brl_pkg::brl_flags_t          flags_o
);

  localparam int CB = COORD_BITS;

  logic signed [CB:0] dx, dy;
  logic [CB-1:0]      adx, ady, dmaj, dmin;
  logic [CB-1:0]      xs, ys, xe, ye;
  logic               steep, swap;

  assign dx  = $signed({1'b0, end_x_i}) - $signed({1'b0, start_x_i});
  assign dy  = $signed({1'b0, end_y_i}) - $signed({1'b0, start_y_i});
  assign adx = dx[CB] ? CB'(-dx) : dx[CB-1:0];
  assign ady = dy[CB] ? CB'(-dy) : dy[CB-1:0];

  // Equal deltas walk along x.
  assign steep = (ady > adx);
  assign swap  = steep ? (start_y_i > end_y_i) : (start_x_i > end_x_i);

  assign xs = swap ? end_x_i   : start_x_i;
  assign ys = swap ? end_y_i   : start_y_i;
  assign xe = swap ? start_x_i : end_x_i;
  assign ye = swap ? start_y_i : end_y_i;

  assign dmaj = steep ? ady : adx;
  assign dmin = steep ? adx : ady;

  assign cur_x_o            = xs;
  assign cur_y_o            = ys;
  assign major_end_o        = steep ? ye : xe;
  assign flags_o.steep      = steep;
  assign flags_o.minor_down = steep ? !(xs < xe) : !(ys < ye);

  assign err_o   = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
  assign inc_s_o = {1'b0, dmin, 1'b0};
  assign inc_d_o = $signed({2'b00, dmin, 1'b0}) - $signed({2'b00, dmaj, 1'b0});

endmodule

### rtl/brl_step.sv
// ----------------------------------------------------------------------------
// Rasterizer pixel step
// Advances the current pixel by one along the major axis.
// ----------------------------------------------------------------------------
module brl_step #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]        cur_x_i,
  input  logic [COORD_BITS-1:0]        cur_y_i,
  input  logic signed [COORD_BITS+2:0] err_i,
  input  logic [COORD_BITS+1:0]        inc_s_i,
  input  logic signed [COORD_BITS+2:0] inc_d_i,
  input  brl_pkg::brl_flags_t          flags_i,
  output logic [COORD_BITS-1:0]        cur_x_o,
  output logic [COORD_BITS-1:0]        cur_y_o,
  output logic signed [COORD_BITS+2:0] err_o
);

  localparam int CB    = COORD_BITS;
  localparam int ERR_W = COORD_BITS + 3;

  logic [CB-1:0] major, minor, major_nx, minor_nx;

  assign major    = flags_i.steep ? cur_y_i : cur_x_i;
  assign minor    = flags_i.steep ? cur_x_i : cur_y_i;
  assign major_nx = major + CB'(1);

  always_comb begin
    if (err_i[ERR_W-1]) begin
      // Straight step: minor coordinate stays.
      err_o    = err_i + $signed({1'b0, inc_s_i});
      minor_nx = minor;
    end else begin
      err_o    = err_i + inc_d_i;
      minor_nx = flags_i.minor_down ? (minor - CB'(1)) : (minor + CB'(1));
    end
  end

  assign cur_x_o = flags_i.steep ? minor_nx : major_nx;
  assign cur_y_o = flags_i.steep ? major_nx : minor_nx;

endmodule

### rtl/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// Bresenham line rasterizer
// Walks a line between two endpoints and produces at most one pixel per item.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-----------------------------
//  in      | input     | in_valid_i / in_stall_o | kind, start_x/y, end_x/y
//  out     | output    | out_valid_o/out_stall_i | pixel_x, pixel_y, last
//
//  One item per cycle is sustained while the output is not stalled; an item
//  enters the input register when accepted and its pixel then moves on to
//  the result register. The add and compare of the error update sit between
//  the input register and the result register.
//  Reset clears the line state, so an advance before any start yields nothing.
//  A stall on the output holds the result register and the input register;
//  the input stall follows only when an item is waiting in the input register.
//
// ----------------------------------------------------------------------------
`include "bresenham_line_rasterizer_macros.svh"

module bresenham_line_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Item input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  kind_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  // Pixel output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_o
);

  localparam int CB    = COORD_BITS;
  localparam int ERR_W = COORD_BITS + 3;
  localparam int INC_W = COORD_BITS + 2;

  // --------------------------------------------------------------------------
  // Input register. It is refilled whenever its item moves on in the same
  // cycle, so items flow at full rate while the output keeps taking results.
  // --------------------------------------------------------------------------
  logic          in_vld_q, in_vld_d;
  logic          out_vld_q, out_vld_d;
  logic          kind_q;
  logic [CB-1:0] sx_q, sy_q, ex_q, ey_q;
  logic          in_take;
  logic          proc;

  assign proc       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !proc;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q <= kind_i;
      sx_q   <= start_x_i;
      sy_q   <= start_y_i;
      ex_q   <= end_x_i;
      ey_q   <= end_y_i;
    end
  end

  // --------------------------------------------------------------------------
  // Line state.
  // --------------------------------------------------------------------------
  logic [CB-1:0]           cur_x_q, cur_y_q, major_end_q;
  logic signed [ERR_W-1:0] err_q;
  logic [INC_W-1:0]        inc_s_q;
  logic signed [ERR_W-1:0] inc_d_q;
  brl_pkg::brl_flags_t     flags_q;
  logic                    active_q;

  // Setup path for a start item.
  logic [CB-1:0]           su_x, su_y, su_end;
  logic signed [ERR_W-1:0] su_err, su_inc_d;
  logic [INC_W-1:0]        su_inc_s;
  brl_pkg::brl_flags_t     su_flags;

  brl_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .start_x_i   (sx_q),
    .start_y_i   (sy_q),
    .end_x_i     (ex_q),
    .end_y_i     (ey_q),
    .cur_x_o     (su_x),
    .cur_y_o     (su_y),
    .major_end_o (su_end),
    .err_o       (su_err),
    .inc_s_o     (su_inc_s),
    .inc_d_o     (su_inc_d),
    .flags_o     (su_flags)
  );

  // Step path for an advance item.
  logic [CB-1:0]           st_x, st_y;
  logic signed [ERR_W-1:0] st_err;

  brl_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .cur_x_i (cur_x_q),
    .cur_y_i (cur_y_q),
    .err_i   (err_q),
    .inc_s_i (inc_s_q),
    .inc_d_i (inc_d_q),
    .flags_i (flags_q),
    .cur_x_o (st_x),
    .cur_y_o (st_y),
    .err_o   (st_err)
  );

  // --------------------------------------------------------------------------
  // Next state and result. A start always plots its first pixel; an advance
  // plots only while a line is active. The pixel whose major coordinate
  // reaches the end is flagged last and closes the line.
  // --------------------------------------------------------------------------
  logic                    is_start, has_res, fin;
  logic [CB-1:0]           x_nx, y_nx, end_nx, major_nx;
  logic signed [ERR_W-1:0] err_nx, inc_d_nx;
  logic [INC_W-1:0]        inc_s_nx;
  brl_pkg::brl_flags_t     flags_nx;

  assign is_start = (kind_q == brl_pkg::KIND_START);
  assign has_res  = is_start || active_q;

  always_comb begin
    if (is_start) begin
      x_nx     = su_x;
      y_nx     = su_y;
      end_nx   = su_end;
      err_nx   = su_err;
      inc_s_nx = su_inc_s;
      inc_d_nx = su_inc_d;
      flags_nx = su_flags;
    end else begin
      x_nx     = st_x;
      y_nx     = st_y;
      end_nx   = major_end_q;
      err_nx   = st_err;
      inc_s_nx = inc_s_q;
      inc_d_nx = inc_d_q;
      flags_nx = flags_q;
    end
  end

  assign major_nx = flags_nx.steep ? y_nx : x_nx;
  assign fin      = (major_nx == end_nx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      major_end_q <= '0;
      err_q       <= '0;
      inc_s_q     <= '0;
      inc_d_q     <= '0;
      flags_q     <= '0;
      active_q    <= 1'b0;
    end else if (proc && has_res) begin
      cur_x_q     <= x_nx;
      cur_y_q     <= y_nx;
      major_end_q <= end_nx;
      err_q       <= err_nx;
      inc_s_q     <= inc_s_nx;
      inc_d_q     <= inc_d_nx;
      flags_q     <= flags_nx;
      active_q    <= !fin;
    end
  end

  // --------------------------------------------------------------------------
  // Result register. It is overwritten only when empty or being taken.
  // --------------------------------------------------------------------------
  logic [CB-1:0] px_q, py_q;
  logic          last_q;

  always_comb begin
    out_vld_d = out_vld_q;
    if (proc && has_res) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && has_res) begin
      px_q   <= x_nx;
      py_q   <= y_nx;
      last_q <= fin;
    end
  end

  assign out_valid_o = out_vld_q;
  assign pixel_x_o   = px_q;
  assign pixel_y_o   = py_q;
  assign last_o      = last_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `BRL_ASSERT_NEXT(a_start_gives_pixel, clk_i, rst_ni, proc && is_start, out_vld_q)
  `BRL_ASSERT_NEXT(a_idle_advance_silent, clk_i, rst_ni, proc && !is_start && !active_q, !out_vld_q)
  `BRL_ASSERT_NEXT(a_last_closes_line, clk_i, rst_ni, proc && has_res && fin, !active_q)
  `BRL_ASSERT_NEXT(a_stall_holds_item, clk_i, rst_ni, in_stall_o, in_vld_q)

endmodule
